// ===== rtl/fbpa_pkg.sv =====
// shared types, widths and codes of the fixed block pool allocator
package fbpa_pkg;

   localparam int MAX_BLOCKS_DEF = 1024;
   localparam int ADDR_WIDTH_DEF = 32;

   localparam int BASE_W     = 32;
   localparam int BSIZE_W    = 16;
   localparam int BCOUNT_W   = 11;
   localparam int REQ_W      = 32;
   localparam int STATUS_W   = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   typedef logic [STATUS_W-1:0]   status_type;
   typedef logic                  command_type;
   typedef logic [CSR_IDX_W-1:0]  csr_index_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   localparam command_type CMD_ALLOC = 1'b0;
   localparam command_type CMD_FREE  = 1'b1;

   localparam status_type STS_SERVED    = 3'd0;
   localparam status_type STS_TOO_LARGE = 3'd1;
   localparam status_type STS_EMPTY     = 3'd2;
   localparam status_type STS_OUTSIDE   = 3'd3;
   localparam status_type STS_FULL      = 3'd4;

   localparam csr_index_type REG_POOL_BASE   = 2'd0;
   localparam csr_index_type REG_BLOCK_SIZE  = 2'd1;
   localparam csr_index_type REG_BLOCK_COUNT = 2'd2;

   localparam logic [BASE_W-1:0]   POOL_BASE_RST   = 32'd0;
   localparam logic [BSIZE_W-1:0]  BLOCK_SIZE_RST  = 16'd64;
   localparam logic [BCOUNT_W-1:0] BLOCK_COUNT_RST = 11'd1024;

endpackage

// ===== rtl/fbpa_req_if.sv =====
// request channel: allocate or free command with its operands
interface fbpa_req_if;
   import fbpa_pkg::*;

   logic                    valid;
   logic                    ready;
   command_type             command;
   logic [REQ_W-1:0]        request_bytes;
   logic [BASE_W-1:0]       free_address;

   modport source (output valid, command, request_bytes, free_address, input ready);
   modport sink (input valid, command, request_bytes, free_address, output ready);
endinterface

// ===== rtl/fbpa_rsp_if.sv =====
// response channel: granted address and status
interface fbpa_rsp_if;
   import fbpa_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [BASE_W-1:0]       block_address;
   status_type              status;

   modport source (output valid, block_address, status, input ready);
   modport sink (input valid, block_address, status, output ready);
endinterface

// ===== rtl/fbpa_csr_if.sv =====
// register write channel
interface fbpa_csr_if;
   import fbpa_pkg::*;

   logic                    valid;
   logic                    ready;
   csr_index_type           index;
   csr_data_type            data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/fixed_block_pool_allocator_core.sv =====
// Fixed-size block pool allocator: a LIFO of free block indices kept in one synchronous
// memory. One command is in work at a time. An allocate reads the stack, multiplies the
// index by the block size and adds the pool base; an allocate refused for size or an
// empty pool goes straight to its response. A free checks the offset against the pool,
// then the restoring divider turns the offset into a block index one quotient bit per
// cycle; a free refused as outside the pool or onto a full stack skips the divider.
// The result sits in an output register, so the next command is taken while a response
// still waits. A write to any of the three registers rebuilds the stack at once with
// every block free; no clearing pass is needed, since a low mark tells which slots
// still hold their initial index.
module fixed_block_pool_allocator_core #(
   parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF,
   parameter int ADDR_WIDTH = fbpa_pkg::ADDR_WIDTH_DEF
) (
   input logic       clock,
   input logic       reset,
   fbpa_req_if.sink  req_chan,
   fbpa_rsp_if.source rsp_chan,
   fbpa_csr_if.sink  csr_chan
);
   import fbpa_pkg::*;

   localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
   localparam int SPAN_W = CNT_W + BSIZE_W;
   localparam int PROD_W = IDX_W + BSIZE_W;
   localparam int AW     = ADDR_WIDTH;
   localparam int CMP_W  = (AW > SPAN_W) ? AW : SPAN_W;
   localparam logic [31:0] MAX32 = 32'(MAX_BLOCKS);
   localparam int RST_EFF = (int'(BLOCK_COUNT_RST) > MAX_BLOCKS) ? MAX_BLOCKS
                                                                 : int'(BLOCK_COUNT_RST);

   typedef enum logic [2:0] {
      ST_IDLE, ST_AIDX, ST_AADD, ST_FCHK, ST_FDIV, ST_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [BASE_W-1:0]    pool_base_ff, pool_base_in;
   logic [BSIZE_W-1:0]   block_size_ff, block_size_in;
   logic [BCOUNT_W-1:0]  block_count_ff, block_count_in;
   logic                 cfg_reinit;
   logic [CNT_W-1:0]     eff_count, eff_new;
   logic [CNT_W-1:0]     fc_ff, fc_in;
   logic [CNT_W-1:0]     lwm_ff, lwm_in;
   logic [CNT_W-1:0]     pop_pos;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [AW-1:0]        offset_ff, offset_in;
   logic [SPAN_W-1:0]    span_ff, span_in;
   logic [AW-1:0]        addr_sum;
   logic [BASE_W-1:0]    res_addr_ff, res_addr_in;
   status_type           res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BASE_W-1:0]    rsp_addr_ff, rsp_addr_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic                 stk_rd_en, stk_wr_en;
   logic [IDX_W-1:0]     stk_rd_data;
   logic                 div_start, div_done;
   logic [IDX_W-1:0]     div_q;
   logic                 req_xfer, csr_xfer;

   assign req_xfer = req_chan.valid && req_chan.ready;
   assign csr_xfer = csr_chan.valid && csr_chan.ready;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.block_address = rsp_addr_ff;
   assign rsp_chan.status        = rsp_status_ff;

   // register writes, any valid index rebuilds the stack
   always_comb begin
      pool_base_in   = pool_base_ff;
      block_size_in  = block_size_ff;
      block_count_in = block_count_ff;
      cfg_reinit     = 1'b0;
      if (csr_xfer) begin
         case (csr_chan.index)
            REG_POOL_BASE: begin
               pool_base_in = csr_chan.data;
               cfg_reinit   = 1'b1;
            end
            REG_BLOCK_SIZE: begin
               block_size_in = csr_chan.data[BSIZE_W-1:0];
               cfg_reinit    = 1'b1;
            end
            REG_BLOCK_COUNT: begin
               block_count_in = csr_chan.data[BCOUNT_W-1:0];
               cfg_reinit     = 1'b1;
            end
            default: begin
               cfg_reinit = 1'b0;
            end
         endcase
      end
   end

   assign eff_count = (32'(block_count_ff) > MAX32) ? CNT_W'(MAX_BLOCKS)
                                                    : CNT_W'(block_count_ff);
   assign eff_new   = (32'(block_count_in) > MAX32) ? CNT_W'(MAX_BLOCKS)
                                                    : CNT_W'(block_count_in);

   assign pop_pos  = fc_ff - CNT_W'(1);
   assign addr_sum = AW'(pool_base_ff) + AW'(prod_ff);

   always_comb begin
      state_in      = state_ff;
      fc_in         = fc_ff;
      lwm_in        = lwm_ff;
      prod_in       = prod_ff;
      offset_in     = offset_ff;
      span_in       = span_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      stk_rd_en     = 1'b0;
      stk_wr_en     = 1'b0;
      div_start     = 1'b0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               res_addr_in = '0;
               if (req_chan.command == CMD_ALLOC) begin
                  if (req_chan.request_bytes > REQ_W'(block_size_ff)) begin
                     res_status_in = STS_TOO_LARGE;
                     state_in      = ST_DONE;
                  end else if (fc_ff == '0) begin
                     res_status_in = STS_EMPTY;
                     state_in      = ST_DONE;
                  end else begin
                     stk_rd_en = 1'b1;
                     fc_in     = pop_pos;
                     lwm_in    = (pop_pos < lwm_ff) ? pop_pos : lwm_ff;
                     state_in  = ST_AIDX;
                  end
               end else begin
                  offset_in = AW'(req_chan.free_address) - AW'(pool_base_ff);
                  span_in   = SPAN_W'(eff_count) * SPAN_W'(block_size_ff);
                  state_in  = ST_FCHK;
               end
            end
         end
         ST_AIDX: begin
            prod_in  = PROD_W'(stk_rd_data) * PROD_W'(block_size_ff);
            state_in = ST_AADD;
         end
         ST_AADD: begin
            res_addr_in   = BASE_W'(addr_sum);
            res_status_in = STS_SERVED;
            state_in      = ST_DONE;
         end
         ST_FCHK: begin
            if ((block_size_ff == '0) || (CMP_W'(offset_ff) >= CMP_W'(span_ff))) begin
               res_status_in = STS_OUTSIDE;
               state_in      = ST_DONE;
            end else if (fc_ff >= eff_count) begin
               res_status_in = STS_FULL;
               state_in      = ST_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = ST_FDIV;
            end
         end
         ST_FDIV: begin
            if (div_done) begin
               stk_wr_en     = 1'b1;
               fc_in         = fc_ff + CNT_W'(1);
               res_status_in = STS_SERVED;
               state_in      = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cfg_reinit) begin
         fc_in  = eff_new;
         lwm_in = eff_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         pool_base_ff   <= POOL_BASE_RST;
         block_size_ff  <= BLOCK_SIZE_RST;
         block_count_ff <= BLOCK_COUNT_RST;
         fc_ff          <= CNT_W'(RST_EFF);
         lwm_ff         <= CNT_W'(RST_EFF);
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         pool_base_ff   <= pool_base_in;
         block_size_ff  <= block_size_in;
         block_count_ff <= block_count_in;
         fc_ff          <= fc_in;
         lwm_ff         <= lwm_in;
      end
      prod_ff       <= prod_in;
      offset_ff     <= offset_in;
      span_ff       <= span_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   fbpa_stack #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_stack (
      .clock    (clock),
      .rd_en    (stk_rd_en),
      .rd_pos   (pop_pos),
      .low_mark (lwm_ff),
      .wr_en    (stk_wr_en),
      .wr_pos   (fc_ff),
      .wr_data  (div_q),
      .rd_data  (stk_rd_data)
   );

   // offset is below the span here, so it fits the narrower dividend
   fbpa_div #(
      .DW (SPAN_W),
      .QB (IDX_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (SPAN_W'(offset_ff)),
      .divisor  (block_size_ff),
      .done     (div_done),
      .quotient (div_q)
   );
endmodule

// ===== rtl/fbpa_stack.sv =====
// free index stack memory, registered read, unwritten slots read as identity
module fbpa_stack #(
   parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
   input  logic                                      clock,
   input  logic                                      rd_en,
   input  logic [$clog2(MAX_BLOCKS+1)-1:0]           rd_pos,
   input  logic [$clog2(MAX_BLOCKS+1)-1:0]           low_mark,
   input  logic                                      wr_en,
   input  logic [$clog2(MAX_BLOCKS+1)-1:0]           wr_pos,
   input  logic [((MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1)-1:0] wr_data,
   output logic [((MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1)-1:0] rd_data
);
   import fbpa_pkg::*;

   localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

   logic [IDX_W-1:0] mem [MAX_BLOCKS];
   logic [IDX_W-1:0] mem_q_ff;
   logic [IDX_W-1:0] pos_ff;
   logic             ident_ff;

   // slots below the low mark were never written since the last reinit
   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_q_ff <= mem[rd_pos[IDX_W-1:0]];
         pos_ff   <= rd_pos[IDX_W-1:0];
         ident_ff <= (rd_pos < low_mark);
      end
      if (wr_en) begin
         mem[wr_pos[IDX_W-1:0]] <= wr_data;
      end
   end

   assign rd_data = ident_ff ? pos_ff : mem_q_ff;
endmodule

// ===== rtl/fbpa_div.sv =====
// restoring divider, one quotient bit per cycle
module fbpa_div #(
   parameter int DW = 27,
   parameter int QB = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [DW-1:0]              dividend,
   input  logic [fbpa_pkg::BSIZE_W-1:0] divisor,
   output logic                       done,
   output logic [QB-1:0]              quotient
);
   import fbpa_pkg::*;

   localparam int CW = $clog2(QB + 1);

   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [QB-1:0] quo_ff, quo_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic          ge;

   assign ge = (rem_ff >= den_ff);

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend;
         den_in  = DW'(divisor) << (QB - 1);
         quo_in  = '0;
         cnt_in  = CW'(QB);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? (rem_ff - den_ff) : rem_ff;
         den_in = den_ff >> 1;
         quo_in = (quo_ff << 1) | QB'(ge);
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// ===== rtl/fbpa_checker.sv =====
// port-level checks of the allocator and their bind
module fbpa_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [fbpa_pkg::BASE_W-1:0]   rsp_block_address,
   input fbpa_pkg::status_type          rsp_status
);
   import fbpa_pkg::*;

   // a stalled response keeps its content
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_block_address)
                                  && $stable(rsp_status))
      else $error("response changed while stalled");

   // one command in work at a time
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in work");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= STS_FULL)
      else $error("status code out of range");

   a_no_grant_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STS_SERVED) |-> rsp_block_address == '0)
      else $error("address given without a grant");

   // a response needs processing time after the request transfer
   a_no_same_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("response appeared without processing time");
endmodule

bind fixed_block_pool_allocator_core fbpa_checker u_fbpa_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_block_address (rsp_chan.block_address),
   .rsp_status        (rsp_chan.status)
);

// ===== tb/fixed_block_pool_allocator_core_tb.sv =====
// testbench for the block pool allocator: allocate and free traffic, checked against a pool mirror
module fixed_block_pool_allocator_core_tb;
   import fbpa_pkg::*;

   localparam int POOL_DEPTH     = MAX_BLOCKS_DEF;
   localparam int IDX_W          = $clog2(POOL_DEPTH);
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int REPORT_LIMIT   = 10;
   localparam int PHASE_COUNT    = 8;
   localparam int PHASE_ITEMS    = 240;

   // index with no register behind it
   localparam csr_index_type REG_UNUSED = 2'd3;

   typedef struct packed {
      logic [BASE_W-1:0] block_address;
      status_type        status;
   } pool_result_type;

   logic clock;
   logic reset;

   fbpa_req_if req_bus ();
   fbpa_rsp_if rsp_bus ();
   fbpa_csr_if csr_bus ();

   fixed_block_pool_allocator_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // mirror of the pool registers and free stack
   logic [BASE_W-1:0]   pool_base_q;
   logic [BSIZE_W-1:0]  block_size_q;
   logic [BCOUNT_W-1:0] block_count_q;
   logic [IDX_W-1:0]    index_stack [POOL_DEPTH];
   int unsigned         stack_depth;

   pool_result_type   pending_results [$];
   logic [BASE_W-1:0] held_blocks [$];
   int                fault_count;
   int                response_count;
   bit                req_raised;
   bit                csr_raised;

   int quiet_cycles;
   int stall_mode;
   int mode_left;
   int hold_left;
   bit ready_next;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int unsigned usable_blocks();
      return (block_count_q > POOL_DEPTH) ? POOL_DEPTH : int'(block_count_q);
   endfunction

   function automatic void restock_pool();
      for (int i = 0; i < POOL_DEPTH; i++) index_stack[i] = IDX_W'(i);
      stack_depth = usable_blocks();
      held_blocks.delete();
   endfunction

   function automatic void apply_register(csr_index_type idx, csr_data_type data);
      case (idx)
         REG_POOL_BASE:   pool_base_q   = data[BASE_W-1:0];
         REG_BLOCK_SIZE:  block_size_q  = data[BSIZE_W-1:0];
         REG_BLOCK_COUNT: block_count_q = data[BCOUNT_W-1:0];
         default: return;
      endcase
      restock_pool();
   endfunction

   function automatic pool_result_type advance_pool(command_type cmd,
                                                    logic [REQ_W-1:0] nbytes,
                                                    logic [BASE_W-1:0] addr);
      pool_result_type   res;
      logic [BASE_W-1:0] offset;
      logic [BASE_W-1:0] span;
      int unsigned       blocks;
      blocks            = usable_blocks();
      res.block_address = '0;
      res.status        = STS_SERVED;
      if (cmd == CMD_ALLOC) begin
         // size check wins over the empty check
         if (nbytes > REQ_W'(block_size_q)) begin
            res.status = STS_TOO_LARGE;
         end else if (stack_depth == 0) begin
            res.status = STS_EMPTY;
         end else begin
            stack_depth--;
            res.block_address = pool_base_q
                              + BASE_W'(index_stack[stack_depth]) * BASE_W'(block_size_q);
            held_blocks.push_back(res.block_address);
         end
      end else begin
         offset = addr - pool_base_q;
         span   = BASE_W'(blocks) * BASE_W'(block_size_q);
         if (block_size_q == 0 || offset >= span) begin
            res.status = STS_OUTSIDE;
         end else if (stack_depth >= blocks) begin
            res.status = STS_FULL;
         end else begin
            index_stack[stack_depth] = IDX_W'(offset / BASE_W'(block_size_q));
            stack_depth++;
         end
      end
      return res;
   endfunction

   task automatic issue_request(command_type cmd, logic [REQ_W-1:0] nbytes,
                                logic [BASE_W-1:0] addr);
      req_bus.valid         <= 1'b1;
      req_bus.command       <= cmd;
      req_bus.request_bytes <= nbytes;
      req_bus.free_address  <= addr;
      req_raised = 1'b1;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      pending_results.push_back(advance_pool(cmd, nbytes, addr));
   endtask

   task automatic issue_alloc(logic [REQ_W-1:0] nbytes);
      issue_request(CMD_ALLOC, nbytes, $urandom);
   endtask

   task automatic issue_free(logic [BASE_W-1:0] addr);
      issue_request(CMD_FREE, $urandom, addr);
   endtask

   task automatic lower_request();
      if (req_raised) begin
         req_bus.valid <= 1'b0;
         req_raised = 1'b0;
      end
   endtask

   task automatic pause_requests(int unsigned n);
      if (n > 0) begin
         lower_request();
         repeat (n) @(posedge clock);
      end
   endtask

   // always waits on the clock before returning, so valid is never lowered and raised in one step
   task automatic drain_pool();
      lower_request();
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic write_register(csr_index_type idx, csr_data_type data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      csr_raised = 1'b1;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      apply_register(idx, data);
   endtask

   task automatic lower_csr();
      if (csr_raised) begin
         csr_bus.valid <= 1'b0;
         csr_raised = 1'b0;
      end
   endtask

   task automatic program_pool(logic [BASE_W-1:0] base, logic [BSIZE_W-1:0] bsize,
                               logic [BCOUNT_W-1:0] bcount, bit with_unused);
      csr_data_type data;
      drain_pool();
      if (with_unused) write_register(REG_UNUSED, $urandom);
      write_register(REG_POOL_BASE, base);
      data = $urandom;
      data[BSIZE_W-1:0] = bsize;
      write_register(REG_BLOCK_SIZE, data);
      data = $urandom;
      data[BCOUNT_W-1:0] = bcount;
      write_register(REG_BLOCK_COUNT, data);
      lower_csr();
   endtask

   task automatic test_default_pool();
      issue_alloc(32'd64);
      issue_alloc(32'd65);
      issue_alloc(32'hFFFF_FFFF);
      issue_alloc(32'd0);
      // last byte of a block maps back to that block
      issue_free(32'h0000_FFC0 + 32'd63);
      issue_free(32'h0000_FF80);
      // double free onto a full stack
      issue_free(32'h0000_FF80);
      issue_free(32'hFFFF_FFFF);
      issue_free(32'h0001_0000);
   endtask

   task automatic test_wrapping_pool();
      program_pool(32'hFFFF_FFF0, 16'hFFFF, 11'd2, 1'b0);
      issue_alloc(32'h0000_FFFF);
      issue_alloc(32'd1);
      issue_alloc(32'd0);
      issue_alloc(32'h0001_0000);
      issue_free(32'hFFFF_FFF0 + 32'h0001_FFFD);
      issue_free(32'hFFFF_FFEF);
      issue_free(32'hFFFF_FFF0 + 32'h0001_FFFE);
   endtask

   task automatic test_degenerate_config();
      logic [BASE_W-1:0] base;
      base = $urandom;
      // zero block size: a zero byte request still gets the base
      program_pool(base, 16'd0, 11'd4, 1'b0);
      issue_alloc(32'd0);
      issue_alloc(32'd1);
      issue_free(base);
      // no blocks at all
      program_pool(base, 16'd16, 11'd0, 1'b0);
      issue_alloc(32'd16);
      issue_free(base);
      // count above the stack depth saturates
      program_pool(32'd0, 16'd8, 11'd2047, 1'b0);
      issue_free(32'd0);
      issue_alloc(32'd8);
   endtask

   task automatic test_unused_register();
      drain_pool();
      write_register(REG_UNUSED, $urandom);
      lower_csr();
      // stack must not have been rebuilt
      issue_alloc(32'd0);
      issue_free(32'd1023 * 32'd8);
   endtask

   task automatic test_random_traffic();
      int unsigned         burst_left;
      int unsigned         pick;
      int unsigned         blocks;
      int unsigned         slot;
      logic [BASE_W-1:0]   base;
      logic [BSIZE_W-1:0]  bsize;
      logic [BCOUNT_W-1:0] bcount;
      logic [BASE_W-1:0]   addr;
      burst_left = 0;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case ($urandom_range(0, 3))
            0:       base = '0;
            1:       base = $urandom;
            2:       base = 32'hFFFF_0000 | $urandom_range(0, 65535);
            default: base = $urandom & 32'hFFFF_F000;
         endcase
         case ($urandom_range(0, 4))
            0:       bsize = BSIZE_W'($urandom_range(1, 16));
            1:       bsize = 16'd1 << $urandom_range(0, 15);
            2:       bsize = BSIZE_W'($urandom_range(1, 65535));
            3:       bsize = 16'hFFFF;
            default: bsize = BSIZE_W'($urandom_range(0, 3));
         endcase
         case ($urandom_range(0, 4))
            0:       bcount = BCOUNT_W'($urandom_range(1, 8));
            1:       bcount = BCOUNT_W'($urandom_range(1, 64));
            2:       bcount = 11'd1024;
            3:       bcount = BCOUNT_W'($urandom_range(1025, 2047));
            default: bcount = BCOUNT_W'($urandom_range(0, 1024));
         endcase
         // first phase pins the small extremes
         if (phase == 0) begin
            base   = 32'hFFFF_FFFF;
            bsize  = 16'd1;
            bcount = 11'd1;
         end
         program_pool(base, bsize, bcount, $urandom_range(0, 2) == 0);
         blocks = usable_blocks();
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (burst_left == 0) begin
               pause_requests(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
               burst_left = $urandom_range(1, 24);
            end
            burst_left--;
            if ($urandom_range(0, 149) == 0) drain_pool();
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
               issue_alloc($urandom_range(0, block_size_q));
            end else if (pick < 45) begin
               issue_alloc($urandom);
            end else if (pick < 80 && held_blocks.size() != 0) begin
               slot = $urandom_range(0, held_blocks.size() - 1);
               addr = held_blocks[slot];
               held_blocks.delete(slot);
               if ($urandom_range(0, 3) == 0 && block_size_q != 0)
                  addr = addr + $urandom_range(0, block_size_q - 1);
               issue_free(addr);
            end else if (pick < 90 && blocks != 0 && block_size_q != 0) begin
               // any block of the pool, so double frees and full pushes happen
               addr = pool_base_q + $urandom_range(0, blocks - 1) * block_size_q
                    + $urandom_range(0, block_size_q - 1);
               issue_free(addr);
            end else begin
               issue_free($urandom);
            end
         end
      end
   endtask

   initial begin
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.command       <= CMD_ALLOC;
      req_bus.request_bytes <= '0;
      req_bus.free_address  <= '0;
      csr_bus.valid         <= 1'b0;
      csr_bus.index         <= REG_POOL_BASE;
      csr_bus.data          <= '0;
      req_raised     = 1'b0;
      csr_raised     = 1'b0;
      fault_count    = 0;
      response_count = 0;
      pool_base_q    = POOL_BASE_RST;
      block_size_q   = BLOCK_SIZE_RST;
      block_count_q  = BLOCK_COUNT_RST;
      restock_pool();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_pool();
      test_wrapping_pool();
      test_degenerate_config();
      test_unused_register();
      test_random_traffic();

      drain_pool();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0 && pending_results.size() == 0) begin
         $display("fixed_block_pool_allocator_core_tb: done, clean");
      end else begin
         $display("fixed_block_pool_allocator_core_tb: done, errors");
      end
      $finish;
   end

   // response check, one transfer per edge
   always @(posedge clock) begin
      pool_result_type want;
      bit              bad;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         response_count++;
         if (pending_results.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
               $display("response %0d with nothing outstanding: address %h status %0d",
                        response_count, rsp_bus.block_address, rsp_bus.status);
         end else begin
            want = pending_results.pop_front();
            bad  = 1'b0;
            if (rsp_bus.block_address !== want.block_address) bad = 1'b1;
            if (rsp_bus.status !== want.status) bad = 1'b1;
            if (bad) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display("response %0d: expected address %h status %0d, got address %h status %0d",
                           response_count, want.block_address, want.status,
                           rsp_bus.block_address, rsp_bus.status);
            end
         end
      end
   end

   // response side back-pressure, switching between stall patterns
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_mode = 0;
         mode_left  = 0;
         hold_left  = 0;
         ready_next = 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(100, 600);
         end else begin
            mode_left--;
         end
         if (hold_left == 0) begin
            case (stall_mode)
               0: begin
                  ready_next = 1'b1;
                  hold_left  = 8;
               end
               1: begin
                  ready_next = ($urandom_range(0, 3) != 0);
                  hold_left  = $urandom_range(0, 2);
               end
               2: begin
                  ready_next = !ready_next;
                  hold_left  = ready_next ? $urandom_range(0, 5) : $urandom_range(1, 20);
               end
               default: begin
                  ready_next = ($urandom_range(0, 3) == 0);
                  hold_left  = $urandom_range(0, 4);
               end
            endcase
            rsp_bus.ready <= ready_next;
         end else begin
            hold_left--;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
                   (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) ||
                   (csr_bus.valid === 1'b1 && csr_bus.ready === 1'b1)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("fixed_block_pool_allocator_core_tb: done, errors");
            $finish;
         end
      end
   end

endmodule
